/* rtl/core/pida_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process ID allocator package
// Shared request and response types, command and status codes, controller
// states and the control and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pida_pkg;

	localparam int PID_BITS  = 10;
	localparam int NAME_BITS = 32;
	localparam int CORE_BITS = 8;

	// Command codes.
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_LOOKUP  = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;

	// Status codes.
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
	localparam logic [1:0] STAT_NOT_ALLOC = 2'd2;

	typedef struct packed {
		logic [1:0]           cmd;
		logic [PID_BITS-1:0]  pid;
		logic [NAME_BITS-1:0] name_handle;
		logic [CORE_BITS-1:0] core;
	} pida_req_t;

	typedef struct packed {
		logic [PID_BITS-1:0]  result_pid;
		logic [1:0]           status;
		logic [NAME_BITS-1:0] found_name;
		logic [CORE_BITS-1:0] found_core;
	} pida_rsp_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} pida_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic capture;
		logic exec;
	} pida_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done;
	} pida_stat_t;

endpackage

/* rtl/core/process_id_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process ID allocator
// Flow: an accepted item is captured, then evaluated in the execute state;
// done and the result are registered together at the end of that state.
// An item is taken only once the last one is through, since the registered
// read of the bitmap, entry store and stack must come before its update.
// Reset: after arst_n is released, busy stays high while the allocation
// bitmap is swept to zero; results are never stalled.
// ----------------------------------------------------------------------------
module process_id_allocator_top #(
	parameter int POOL_SIZE = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  pida_pkg::pida_req_t req,
	output logic                done,
	output pida_pkg::pida_rsp_t rsp
);

	import pida_pkg::*;

	pida_ctrl_t ctrl;
	pida_stat_t stat;

	// Sequencer.
	pida_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// Storage and result logic.
	pida_dp #(.POOL_SIZE(POOL_SIZE)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.req    (req),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

/* rtl/core/pida_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pida_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/pida_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process ID allocator controller
// Sequences the clearing sweep after reset and the capture and execute
// states of each item.
// ----------------------------------------------------------------------------
module pida_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  pida_pkg::pida_stat_t stat,
	output pida_pkg::pida_ctrl_t ctrl,
	output logic                 busy
);

	import pida_pkg::*;

	pida_state_t state_q;
	pida_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		busy    = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				ctrl.clear = 1'b1;
				if (stat.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctrl.capture = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctrl.exec = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/pida_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process ID allocator datapath
// Holds the allocation bitmap, the name and core store, the stack of
// released identifiers and the counters, and forms each result.
// ----------------------------------------------------------------------------
module pida_dp #(
	parameter int POOL_SIZE = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pida_pkg::pida_ctrl_t ctrl,
	input  pida_pkg::pida_req_t  req,
	output pida_pkg::pida_stat_t stat,
	output logic                 done,
	output pida_pkg::pida_rsp_t  rsp
);

	import pida_pkg::*;

	localparam int IW = $clog2(POOL_SIZE);
	localparam int CW = $clog2(POOL_SIZE + 1);
	localparam int EW = NAME_BITS + CORE_BITS;

	// Captured request.
	pida_req_t req_q;
	logic      pid_ok_q;

	// Control counters.
	logic [IW-1:0] clr_cnt_q;
	logic [CW-1:0] rec_cnt_q;
	logic [CW-1:0] rec_cnt_d;
	logic [CW-1:0] rec_dec;
	logic [CW-1:0] fresh_q;
	logic [CW-1:0] fresh_d;

	// Result registers.
	logic      done_q;
	pida_rsp_t rsp_q;
	pida_rsp_t rsp_d;

	// Memory ports.
	logic          iu_we;
	logic [IW-1:0] iu_waddr;
	logic          iu_wdata;
	logic          iu_rdata;
	logic          ent_we;
	logic [IW-1:0] ent_waddr;
	logic [EW-1:0] ent_rdata;
	logic          stk_we;
	logic [IW-1:0] stk_rdata;
	logic [IW-1:0] in_idx;
	logic [IW-1:0] pid_idx_q;
	logic [IW-1:0] alloc_id;
	logic          in_pid_ok;

	// Bitmap and entry read addresses come straight from the item being accepted.
	assign in_idx    = IW'(req.pid);
	assign in_pid_ok = (32'(req.pid) < 32'(POOL_SIZE));
	assign rec_dec   = rec_cnt_q - CW'(1);
	assign pid_idx_q = IW'(req_q.pid);
	assign alloc_id  = (rec_cnt_q != '0) ? stk_rdata : fresh_q[IW-1:0];

	pida_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_in_use (
		.clk   (clk),
		.we    (iu_we),
		.waddr (iu_waddr),
		.wdata (iu_wdata),
		.raddr (in_idx),
		.rdata (iu_rdata)
	);

	pida_ram #(.WIDTH(EW), .DEPTH(POOL_SIZE)) u_entry (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata ({req_q.name_handle, req_q.core}),
		.raddr (in_idx),
		.rdata (ent_rdata)
	);

	pida_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (rec_cnt_q[IW-1:0]),
		.wdata (pid_idx_q),
		.raddr (rec_dec[IW-1:0]),
		.rdata (stk_rdata)
	);

	// Item evaluation and memory updates.
	always_comb begin
		iu_we      = 1'b0;
		iu_waddr   = pid_idx_q;
		iu_wdata   = 1'b0;
		ent_we     = 1'b0;
		ent_waddr  = alloc_id;
		stk_we     = 1'b0;
		rec_cnt_d  = rec_cnt_q;
		fresh_d    = fresh_q;
		rsp_d            = '0;
		rsp_d.result_pid = req_q.pid;
		rsp_d.status     = STAT_OK;
		if (ctrl.clear) begin
			iu_we    = 1'b1;
			iu_waddr = clr_cnt_q;
		end
		if (ctrl.exec) begin
			case (req_q.cmd)
				CMD_ALLOC: begin
					if (rec_cnt_q != '0 || fresh_q < CW'(POOL_SIZE)) begin
						if (rec_cnt_q != '0) begin
							rec_cnt_d = rec_dec;
						end else begin
							fresh_d = fresh_q + CW'(1);
						end
						iu_we            = 1'b1;
						iu_waddr         = alloc_id;
						iu_wdata         = 1'b1;
						ent_we           = 1'b1;
						rsp_d.result_pid = PID_BITS'(alloc_id);
					end else begin
						rsp_d.result_pid = '0;
						rsp_d.status     = STAT_EXHAUSTED;
					end
				end
				CMD_LOOKUP: begin
					if (pid_ok_q && iu_rdata) begin
						rsp_d.found_name = ent_rdata[EW-1:CORE_BITS];
						rsp_d.found_core = ent_rdata[CORE_BITS-1:0];
					end else begin
						rsp_d.status = STAT_NOT_ALLOC;
					end
				end
				CMD_RELEASE: begin
					if (pid_ok_q && iu_rdata && rec_cnt_q < CW'(POOL_SIZE)) begin
						iu_we     = 1'b1;
						stk_we    = 1'b1;
						rec_cnt_d = rec_cnt_q + CW'(1);
					end else begin
						rsp_d.status = STAT_NOT_ALLOC;
					end
				end
				default: begin
					rsp_d.status = STAT_OK;
				end
			endcase
		end
	end

	assign stat.clear_done = (clr_cnt_q == IW'(POOL_SIZE - 1));

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			rec_cnt_q <= '0;
			fresh_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				clr_cnt_q <= clr_cnt_q + IW'(1);
			end
			rec_cnt_q <= rec_cnt_d;
			fresh_q   <= fresh_d;
			done_q    <= ctrl.exec;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			req_q    <= req;
			pid_ok_q <= in_pid_ok;
		end
		if (ctrl.exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process ID allocator testbench
// Sends allocate, lookup, release and unused commands through the start/busy
// handshake and checks every response against a predicted free-list model.
// ----------------------------------------------------------------------------
module tb;

	import pida_pkg::*;

	localparam int POOL = 1024;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	pida_req_t req;
	logic      done;
	pida_rsp_t rsp;

	// Predicted allocator state.
	bit                   pid_taken [POOL];
	logic [NAME_BITS-1:0] name_tab [POOL];
	logic [CORE_BITS-1:0] core_tab [POOL];
	logic [PID_BITS-1:0]  free_stack [POOL];
	int                   free_depth;
	int                   next_fresh;
	logic [PID_BITS-1:0]  live_pids [$];

	pida_rsp_t rsp_q [$];
	int        mismatches;
	bit        no_gaps;

	process_id_allocator_top #(
		.POOL_SIZE(POOL)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit: far beyond the clearing pass plus every item at its longest gap.
	initial begin
		#3_000_000;
		$display("[process_id_allocator_top] ERROR");
		$finish;
	end

	// Drop a pid from the list of allocated identifiers.
	function automatic void forget_pid(logic [PID_BITS-1:0] p);
		for (int i = 0; i < live_pids.size(); i++) begin
			if (live_pids[i] == p) begin
				live_pids.delete(i);
				return;
			end
		end
	endfunction

	// Work out the response to one accepted item and update the free list.
	function automatic pida_rsp_t allocator_response(pida_req_t r);
		pida_rsp_t o;
		logic [PID_BITS-1:0] id;
		o.result_pid = r.pid;
		o.status     = STAT_OK;
		o.found_name = '0;
		o.found_core = '0;
		case (r.cmd)
			CMD_ALLOC: begin
				if (free_depth > 0 || next_fresh < POOL) begin
					if (free_depth > 0) begin
						free_depth--;
						id = free_stack[free_depth];
					end else begin
						id = PID_BITS'(next_fresh);
						next_fresh++;
					end
					pid_taken[id] = 1'b1;
					name_tab[id]  = r.name_handle;
					core_tab[id]  = r.core;
					live_pids.push_back(id);
					o.result_pid = id;
				end else begin
					o.result_pid = '0;
					o.status     = STAT_EXHAUSTED;
				end
			end
			CMD_LOOKUP: begin
				if (pid_taken[r.pid]) begin
					o.found_name = name_tab[r.pid];
					o.found_core = core_tab[r.pid];
				end else begin
					o.status = STAT_NOT_ALLOC;
				end
			end
			CMD_RELEASE: begin
				if (pid_taken[r.pid] && free_depth < POOL) begin
					pid_taken[r.pid]       = 1'b0;
					free_stack[free_depth] = r.pid;
					free_depth++;
					forget_pid(r.pid);
				end else begin
					o.status = STAT_NOT_ALLOC;
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	// Send one item: optional gap, then hold start until the block takes it.
	task automatic send_item(logic [1:0] c, logic [PID_BITS-1:0] p,
			logic [NAME_BITS-1:0] nm, logic [CORE_BITS-1:0] cr);
		int gap;
		pida_req_t item;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		item.cmd         = c;
		item.pid         = p;
		item.name_handle = nm;
		item.core        = cr;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= item;
		@(posedge clk);
		while (busy) @(posedge clk);
		rsp_q.push_back(allocator_response(item));
	endtask

	function automatic logic [PID_BITS-1:0] any_live_pid();
		return live_pids[$urandom_range(0, live_pids.size() - 1)];
	endfunction

	// Check each result against the oldest expected response.
	always @(posedge clk) begin
		pida_rsp_t want;
		if (arst_n && done) begin
			if (rsp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: pid %0d status %0d", rsp.result_pid,
						rsp.status);
			end else begin
				want = rsp_q.pop_front();
				if (rsp !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp pid %0d st %0d name %h core %h, got pid %0d st %0d name %h core %h",
							want.result_pid, want.status, want.found_name, want.found_core,
							rsp.result_pid, rsp.status, rsp.found_name, rsp.found_core);
				end
			end
		end
	end

	// Extremes of the fields, reuse order, double release and the unused command.
	task automatic test_directed();
		send_item(CMD_ALLOC, 10'h3FF, 32'h0000_0000, 8'h00);
		send_item(CMD_ALLOC, 10'h000, 32'hFFFF_FFFF, 8'hFF);
		send_item(CMD_ALLOC, 10'h155, 32'h5A5A_5A5A, 8'h80);
		send_item(CMD_LOOKUP, 10'd0, '0, '0);
		send_item(CMD_LOOKUP, 10'd1, 32'hFFFF_FFFF, 8'hFF);
		send_item(CMD_LOOKUP, 10'h3FF, '0, '0);
		send_item(CMD_LOOKUP, 10'd3, '0, '0);
		send_item(CMD_RELEASE, 10'd1, '0, '0);
		send_item(CMD_RELEASE, 10'd1, '0, '0);
		send_item(CMD_LOOKUP, 10'd1, '0, '0);
		send_item(CMD_RELEASE, 10'd0, '0, '0);
		send_item(CMD_RELEASE, 10'd2, '0, '0);
		// Released identifiers come back most recent first, then fresh ones.
		send_item(CMD_ALLOC, 10'd0, 32'h1234_5678, 8'h01);
		send_item(CMD_ALLOC, 10'd0, 32'h8765_4321, 8'h7F);
		send_item(CMD_ALLOC, 10'd0, 32'hDEAD_BEEF, 8'hFE);
		send_item(CMD_ALLOC, 10'd0, 32'hCAFE_F00D, 8'h10);
		send_item(CMD_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 8'hFF);
		send_item(CMD_UNUSED, 10'h000, 32'h0000_0000, 8'h00);
		send_item(CMD_RELEASE, 10'h3FF, '0, '0);
		send_item(CMD_LOOKUP, 10'd2, '0, '0);
	endtask

	// Allocate until the pool runs dry, with lookups mixed in, then hit exhaustion.
	task automatic test_fill_and_exhaust();
		int n;
		n = 0;
		while (next_fresh < POOL || free_depth > 0) begin
			no_gaps = ((n / 64) % 3) == 1;
			if ($urandom_range(0, 99) < 8)
				send_item(CMD_LOOKUP, any_live_pid(), $urandom, CORE_BITS'($urandom));
			else
				send_item(CMD_ALLOC, PID_BITS'($urandom), $urandom, CORE_BITS'($urandom));
			n++;
		end
		no_gaps = 1'b0;
		repeat (3) send_item(CMD_ALLOC, PID_BITS'($urandom), $urandom, CORE_BITS'($urandom));
		send_item(CMD_LOOKUP, 10'h3FF, '0, '0);
		send_item(CMD_LOOKUP, 10'h000, '0, '0);
	endtask

	// Build a deep stack of released identifiers and allocate them back.
	task automatic test_drain_and_refill();
		for (int i = 0; i < 150; i++) begin
			no_gaps = i >= 100;
			if ($urandom_range(0, 9) == 0)
				send_item(CMD_RELEASE, PID_BITS'($urandom), $urandom, CORE_BITS'($urandom));
			else
				send_item(CMD_RELEASE, any_live_pid(), $urandom, CORE_BITS'($urandom));
		end
		for (int i = 0; i < 150; i++) begin
			no_gaps = i < 40;
			send_item(CMD_ALLOC, PID_BITS'($urandom), $urandom, CORE_BITS'($urandom));
		end
		no_gaps = 1'b0;
	endtask

	// Random mix of all commands over allocated and arbitrary identifiers.
	task automatic test_random_mix();
		int r;
		for (int i = 0; i < 150; i++) begin
			no_gaps = (i % 50) >= 35;
			r = $urandom_range(0, 99);
			if (r < 35 || live_pids.size() == 0)
				send_item(CMD_ALLOC, PID_BITS'($urandom), $urandom, CORE_BITS'($urandom));
			else if (r < 60)
				send_item(CMD_RELEASE, any_live_pid(), $urandom, CORE_BITS'($urandom));
			else if (r < 85)
				send_item(CMD_LOOKUP, any_live_pid(), $urandom, CORE_BITS'($urandom));
			else if (r < 92)
				send_item(CMD_LOOKUP, PID_BITS'($urandom), $urandom, CORE_BITS'($urandom));
			else if (r < 97)
				send_item(CMD_RELEASE, PID_BITS'($urandom), $urandom, CORE_BITS'($urandom));
			else
				send_item(CMD_UNUSED, PID_BITS'($urandom), $urandom, CORE_BITS'($urandom));
		end
		no_gaps = 1'b0;
	endtask

	// Reset, tests in turn, drain and verdict.
	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		req        = '0;
		mismatches = 0;
		no_gaps    = 1'b0;
		free_depth = 0;
		next_fresh = 0;
		for (int i = 0; i < POOL; i++) pid_taken[i] = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_exhaust();
		test_drain_and_refill();
		test_random_mix();

		@(posedge clk);
		start <= 1'b0;
		while (rsp_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0) begin
			$display("[process_id_allocator_top] OK");
		end else begin
			$display("[process_id_allocator_top] ERROR");
		end
		$finish;
	end

endmodule
